/* rtl/savc_pkg.sv */
package savc_pkg;

  // default geometry
  localparam int unsigned MAX_SETS_DEF = 1024;
  localparam int unsigned WAYS_DEF = 4;
  localparam int unsigned VICTIM_ENTRIES_DEF = 8;

  // register map (word index)
  localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [1:0] REG_INDEX_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS = 2'd2;
  localparam logic [1:0] REG_VICTIMS = 2'd3;

  // register reset values
  localparam logic [3:0] OFFSET_BITS_RST = 4'd5;
  localparam logic [3:0] INDEX_BITS_RST = 4'd6;
  localparam logic [2:0] WAYS_RST = 3'd4;
  localparam logic [3:0] VICTIMS_RST = 4'd8;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK
  } state_t;

  // floor(log2(n)), n >= 1
  function automatic int unsigned floor_log2(input int unsigned n);
    int unsigned b;
    b = 0;
    for (int i = 1; i < 32; i++) begin
      if ((64'd1 << i) <= 64'(n)) b = i;
    end
    return b;
  endfunction

endpackage

/* rtl/set_assoc_cache_with_victim_buffer.sv */
// An accepted input beat is registered with its set row read; its result is written to the output register
// once the output is not stalled. No new access is taken until that result is registered; the set row is read
// from a synchronous memory, then the updated row is written back while the result is registered.
// Reset: synchronous; clears control state and registers, then sweeps every row of the set memory
// one row per cycle, during which no access is taken (config writes are).
module set_assoc_cache_with_victim_buffer #(
  parameter int unsigned MAX_SETS = savc_pkg::MAX_SETS_DEF,
  parameter int unsigned WAYS = savc_pkg::WAYS_DEF,
  parameter int unsigned VICTIM_ENTRIES = savc_pkg::VICTIM_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // APB config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        operation,
  input  logic [31:0] address,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        hit,
  output logic        victim_hit,
  output logic        fill_valid,
  output logic [31:0] fill_address,
  output logic        writeback_valid,
  output logic [31:0] writeback_address
);

  localparam int unsigned SW = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned LOG_SETS = savc_pkg::floor_log2(MAX_SETS);
  localparam int unsigned AW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned VAW = (VICTIM_ENTRIES > 1) ? $clog2(VICTIM_ENTRIES) : 1;
  localparam int unsigned EW = AW + 34;
  localparam int unsigned ROW_W = EW * WAYS;
  localparam logic [AW-1:0] AGE_MAX = AW'(WAYS - 1);
  localparam logic [VAW-1:0] VAGE_MAX = VAW'(VICTIM_ENTRIES - 1);

  // config registers
  logic [3:0] offset_bits;
  logic [3:0] index_bits;
  logic [2:0] ways_in_use;
  logic [3:0] victim_entries_in_use;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= savc_pkg::OFFSET_BITS_RST;
      index_bits <= savc_pkg::INDEX_BITS_RST;
      ways_in_use <= savc_pkg::WAYS_RST;
      victim_entries_in_use <= savc_pkg::VICTIMS_RST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        savc_pkg::REG_OFFSET_BITS: offset_bits <= pwdata[3:0];
        savc_pkg::REG_INDEX_BITS:  index_bits <= pwdata[3:0];
        savc_pkg::REG_WAYS:        ways_in_use <= pwdata[2:0];
        savc_pkg::REG_VICTIMS:     victim_entries_in_use <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      savc_pkg::REG_OFFSET_BITS: prdata = {28'd0, offset_bits};
      savc_pkg::REG_INDEX_BITS:  prdata = {28'd0, index_bits};
      savc_pkg::REG_WAYS:        prdata = {29'd0, ways_in_use};
      savc_pkg::REG_VICTIMS:     prdata = {28'd0, victim_entries_in_use};
      default:                   prdata = 32'd0;
    endcase
  end

  // effective geometry
  logic [4:0] ib_eff;
  logic [5:0] tag_sh;
  logic [4:0] nw;
  logic [5:0] nv;

  assign ib_eff = (5'(index_bits) < 5'(LOG_SETS)) ? 5'(index_bits) : 5'(LOG_SETS);
  assign tag_sh = 6'(offset_bits) + 6'(ib_eff);
  assign nw = (ways_in_use == 3'd0) ? 5'd1 :
              (5'(ways_in_use) > 5'(WAYS)) ? 5'(WAYS) : 5'(ways_in_use);
  assign nv = (victim_entries_in_use == 4'd0) ? 6'd1 :
              (6'(victim_entries_in_use) > 6'(VICTIM_ENTRIES)) ? 6'(VICTIM_ENTRIES)
                                                              : 6'(victim_entries_in_use);

  // control
  savc_pkg::state_t state, state_next;
  logic [SW:0]    clr_cnt;
  logic           in_acc;
  logic           look_go;
  logic           q_op;
  logic [31:0]    q_addr;
  logic [SW-1:0]  q_set;
  logic [SW-1:0]  in_set;
  logic [31:0]    set_mask;

  assign in_stall = (state != savc_pkg::S_IDLE);
  assign in_acc = in_valid && !in_stall;
  assign look_go = (state == savc_pkg::S_LOOK) && !(out_valid && out_stall);
  assign set_mask = ~(32'hFFFF_FFFF << ib_eff);
  assign in_set = SW'((address >> offset_bits) & set_mask);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= savc_pkg::S_CLEAR;
      clr_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == savc_pkg::S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      savc_pkg::S_CLEAR: if (clr_cnt == (SW + 1)'(MAX_SETS - 1)) state_next = savc_pkg::S_IDLE;
      savc_pkg::S_IDLE:  if (in_acc) state_next = savc_pkg::S_LOOK;
      savc_pkg::S_LOOK:  if (look_go) state_next = savc_pkg::S_IDLE;
      default:           state_next = savc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      q_op <= operation;
      q_addr <= address;
      q_set <= in_set;
    end
  end

  // set memory: one row per set, way j at [j*EW +: EW] = {addr, age, dirty, valid}
  logic [ROW_W-1:0] mem [MAX_SETS];
  logic [ROW_W-1:0] rd_data;
  logic [ROW_W-1:0] wr_data;
  logic             mem_we;
  logic [SW-1:0]    mem_wa;
  logic [ROW_W-1:0] mem_wd;

  assign mem_we = (state == savc_pkg::S_CLEAR) || look_go;
  assign mem_wa = (state == savc_pkg::S_CLEAR) ? clr_cnt[SW-1:0] : q_set;
  assign mem_wd = (state == savc_pkg::S_CLEAR) ? '0 : wr_data;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (in_acc) rd_data <= mem[in_set];
  end

  // victim buffer
  logic             v_valid [VICTIM_ENTRIES];
  logic             v_dirty [VICTIM_ENTRIES];
  logic [VAW-1:0]   v_age   [VICTIM_ENTRIES];
  logic [31:0]      v_addr  [VICTIM_ENTRIES];
  logic             nv_valid [VICTIM_ENTRIES];
  logic             nv_dirty [VICTIM_ENTRIES];
  logic [VAW-1:0]   nv_age   [VICTIM_ENTRIES];
  logic [31:0]      nv_addr  [VICTIM_ENTRIES];

  // lookup and update
  logic             r_valid [WAYS];
  logic             r_dirty [WAYS];
  logic [AW-1:0]    r_age   [WAYS];
  logic [31:0]      r_addr  [WAYS];
  logic             r_hit, r_vhit, r_fill, r_wb;
  logic [31:0]      r_wb_addr;

  always_comb begin
    logic             n_valid [WAYS];
    logic             n_dirty [WAYS];
    logic [AW-1:0]    n_age   [WAYS];
    logic [31:0]      n_addr  [WAYS];
    logic             found, freef, vfound, vfree, pdirty;
    logic [AW-1:0]    h, fw, lru, place_w, ha;
    logic [VAW-1:0]   vh, pos;
    logic [31:0]      ev_addr;
    logic             ev_dirty, do_place;
    found = 1'b0; freef = 1'b0; vfound = 1'b0; vfree = 1'b0; pdirty = 1'b0;
    h = '0; fw = '0; lru = '0; place_w = '0; vh = '0; pos = '0;
    do_place = 1'b0;
    r_hit = 1'b0; r_vhit = 1'b0; r_fill = 1'b0; r_wb = 1'b0; r_wb_addr = '0;
    for (int j = 0; j < WAYS; j++) begin
      r_valid[j] = rd_data[j*EW];
      r_dirty[j] = rd_data[j*EW+1];
      r_age[j] = rd_data[j*EW+2 +: AW];
      r_addr[j] = rd_data[j*EW+2+AW +: 32];
      n_valid[j] = r_valid[j];
      n_dirty[j] = r_dirty[j];
      n_age[j] = r_age[j];
      n_addr[j] = r_addr[j];
    end
    for (int j = 0; j < VICTIM_ENTRIES; j++) begin
      nv_valid[j] = v_valid[j];
      nv_dirty[j] = v_dirty[j];
      nv_age[j] = v_age[j];
      nv_addr[j] = v_addr[j];
    end
    // way search
    for (int j = 0; j < WAYS; j++) begin
      if (j < int'(nw)) begin
        if (r_valid[j]) begin
          if (!found && ((r_addr[j] >> tag_sh) == (q_addr >> tag_sh))) begin
            found = 1'b1;
            h = AW'(j);
          end
        end else if (!freef) begin
          freef = 1'b1;
          fw = AW'(j);
        end
      end
    end
    // LRU way, lowest index on tie
    for (int j = 1; j < WAYS; j++) begin
      if (j < int'(nw) && r_age[j] > r_age[lru]) lru = AW'(j);
    end
    ev_addr = r_addr[lru];
    ev_dirty = r_dirty[lru];
    ha = r_age[h];

    if (found) begin
      // L1 hit: refresh LRU
      for (int j = 0; j < WAYS; j++) begin
        if (j < int'(nw) && r_valid[j] && AW'(j) != h && r_age[j] < ha)
          n_age[j] = (r_age[j] < AGE_MAX) ? r_age[j] + 1'b1 : r_age[j];
      end
      n_addr[h] = q_addr;
      n_dirty[h] = r_dirty[h] | q_op;
      n_age[h] = '0;
      r_hit = 1'b1;
    end else if (freef) begin
      do_place = 1'b1;
      place_w = fw;
      pdirty = q_op;
      r_fill = 1'b1;
    end else begin
      n_valid[lru] = 1'b0;
      do_place = 1'b1;
      place_w = lru;
      // victim search by block address
      for (int j = 0; j < VICTIM_ENTRIES; j++) begin
        if (j < int'(nv) && !vfound && v_valid[j] &&
            ((v_addr[j] >> offset_bits) == (q_addr >> offset_bits))) begin
          vfound = 1'b1;
          vh = VAW'(j);
        end
      end
      if (vfound) begin
        pdirty = q_op | v_dirty[vh];
        nv_addr[vh] = ev_addr;
        nv_dirty[vh] = ev_dirty;
        r_hit = 1'b1;
        r_vhit = 1'b1;
      end else begin
        for (int j = 0; j < VICTIM_ENTRIES; j++) begin
          if (j < int'(nv) && !vfree && !v_valid[j]) begin
            vfree = 1'b1;
            pos = VAW'(j);
          end
        end
        if (!vfree) begin
          pos = '0;
          for (int j = 1; j < VICTIM_ENTRIES; j++) begin
            if (j < int'(nv) && v_age[j] > v_age[pos]) pos = VAW'(j);
          end
          r_wb = v_dirty[pos];
          r_wb_addr = v_dirty[pos] ? v_addr[pos] : 32'd0;
        end
        for (int j = 0; j < VICTIM_ENTRIES; j++) begin
          if (j < int'(nv) && v_valid[j] && VAW'(j) != pos)
            nv_age[j] = (v_age[j] < VAGE_MAX) ? v_age[j] + 1'b1 : v_age[j];
        end
        nv_addr[pos] = ev_addr;
        nv_dirty[pos] = ev_dirty;
        nv_valid[pos] = 1'b1;
        nv_age[pos] = '0;
        pdirty = q_op;
        r_fill = 1'b1;
      end
    end

    // place new line, age the other valid ways
    if (do_place) begin
      for (int j = 0; j < WAYS; j++) begin
        if (j < int'(nw) && n_valid[j] && AW'(j) != place_w)
          n_age[j] = (r_age[j] < AGE_MAX) ? r_age[j] + 1'b1 : r_age[j];
      end
      n_addr[place_w] = q_addr;
      n_dirty[place_w] = pdirty;
      n_valid[place_w] = 1'b1;
      n_age[place_w] = '0;
    end

    for (int j = 0; j < WAYS; j++) begin
      wr_data[j*EW +: EW] = {n_addr[j], n_age[j], n_dirty[j], n_valid[j]};
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < VICTIM_ENTRIES; j++) begin
      if (rst) begin
        v_valid[j] <= 1'b0;
      end else if (look_go) begin
        v_valid[j] <= nv_valid[j];
      end
      if (look_go) begin
        v_dirty[j] <= nv_dirty[j];
        v_age[j] <= nv_age[j];
        v_addr[j] <= nv_addr[j];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (look_go) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
    if (look_go) begin
      hit <= r_hit;
      victim_hit <= r_vhit;
      fill_valid <= r_fill;
      fill_address <= r_fill ? q_addr : 32'd0;
      writeback_valid <= r_wb;
      writeback_address <= r_wb_addr;
    end
  end

endmodule

/* sim/tb.sv */
module tb;

  localparam int unsigned NSETS = savc_pkg::MAX_SETS_DEF;
  localparam int unsigned NWAYS = savc_pkg::WAYS_DEF;
  localparam int unsigned NVICT = savc_pkg::VICTIM_ENTRIES_DEF;
  localparam int unsigned IDX_MAX = 10;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam bit OP_READ = 1'b0;
  localparam bit OP_WRITE = 1'b1;

  typedef struct packed {
    logic        hit;
    logic        victim_hit;
    logic        fill_valid;
    logic [31:0] fill_address;
    logic        writeback_valid;
    logic [31:0] writeback_address;
  } access_result_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic        operation;
  logic [31:0] address;
  logic        out_valid;
  logic        out_stall;
  logic        hit;
  logic        victim_hit;
  logic        fill_valid;
  logic [31:0] fill_address;
  logic        writeback_valid;
  logic [31:0] writeback_address;

  set_assoc_cache_with_victim_buffer i_dut (.*);

  // shadow copy of the cache state and registers
  logic [3:0]  cfg_offset;
  logic [3:0]  cfg_index;
  logic [2:0]  cfg_ways;
  logic [3:0]  cfg_victims;
  bit          l1_valid [NSETS*NWAYS];
  bit          l1_dirty [NSETS*NWAYS];
  logic [1:0]  l1_age [NSETS*NWAYS];
  logic [31:0] l1_addr [NSETS*NWAYS];
  bit          vb_valid [NVICT];
  bit          vb_dirty [NVICT];
  logic [2:0]  vb_age [NVICT];
  logic [31:0] vb_addr [NVICT];

  access_result_t expected_results[$];
  int          errors;
  bit          calm;
  int          hold_reqs;
  logic [31:0] tag_pool [16];
  int          set_span;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // place a block in an L1 way; the other valid ways age by one
  function automatic void place_line(int base, int w, logic [31:0] a, bit d, int n);
    for (int j = 0; j < n; j++)
      if (l1_valid[base+j] && j != w && l1_age[base+j] < NWAYS-1)
        l1_age[base+j] = l1_age[base+j] + 2'd1;
    l1_addr[base+w] = a;
    l1_dirty[base+w] = d;
    l1_valid[base+w] = 1'b1;
    l1_age[base+w] = '0;
  endfunction

  function automatic access_result_t predict_access(bit wr, logic [31:0] a);
    int ob, ib, base, n, nv, found, freew, lru, pos, vh;
    logic [31:0] tag, blk, ev_a;
    logic [1:0] ha;
    bit ev_d, d, vfound, vfree;
    access_result_t r;
    r = '0;
    ob = cfg_offset;
    ib = (cfg_index > IDX_MAX) ? IDX_MAX : cfg_index;
    base = int'((a >> ob) & ((32'd1 << ib) - 1)) * NWAYS;
    tag = a >> (ob + ib);
    blk = a >> ob;
    n = (cfg_ways < 1) ? 1 : (cfg_ways > NWAYS) ? NWAYS : cfg_ways;
    nv = (cfg_victims < 1) ? 1 : (cfg_victims > NVICT) ? NVICT : cfg_victims;
    found = -1;
    freew = -1;
    for (int j = 0; j < n; j++) begin
      if (l1_valid[base+j]) begin
        if (found < 0 && (l1_addr[base+j] >> (ob + ib)) == tag) found = j;
      end else if (freew < 0) freew = j;
    end
    // L1 hit
    if (found >= 0) begin
      ha = l1_age[base+found];
      for (int j = 0; j < n; j++)
        if (l1_valid[base+j] && j != found && l1_age[base+j] < ha)
          l1_age[base+j] = l1_age[base+j] + 2'd1;
      l1_addr[base+found] = a;
      if (wr) l1_dirty[base+found] = 1'b1;
      l1_age[base+found] = '0;
      r.hit = 1'b1;
      return r;
    end
    // free way: fill without looking at the victim buffer
    if (freew >= 0) begin
      place_line(base, freew, a, wr, n);
      r.fill_valid = 1'b1;
      r.fill_address = a;
      return r;
    end
    // full set: evict LRU way
    lru = 0;
    for (int j = 1; j < n; j++)
      if (l1_age[base+j] > l1_age[base+lru]) lru = j;
    ev_a = l1_addr[base+lru];
    ev_d = l1_dirty[base+lru];
    l1_valid[base+lru] = 1'b0;
    vfound = 1'b0;
    vh = 0;
    for (int j = 0; j < nv; j++)
      if (!vfound && vb_valid[j] && (vb_addr[j] >> ob) == blk) begin
        vh = j;
        vfound = 1'b1;
      end
    // victim hit: swap, entry keeps its age
    if (vfound) begin
      d = wr ? 1'b1 : vb_dirty[vh];
      vb_addr[vh] = ev_a;
      vb_dirty[vh] = ev_d;
      place_line(base, lru, a, d, n);
      r.hit = 1'b1;
      r.victim_hit = 1'b1;
      return r;
    end
    vfree = 1'b0;
    pos = 0;
    for (int j = 0; j < nv; j++)
      if (!vfree && !vb_valid[j]) begin
        pos = j;
        vfree = 1'b1;
      end
    if (!vfree) begin
      for (int j = 1; j < nv; j++)
        if (vb_age[j] > vb_age[pos]) pos = j;
      if (vb_dirty[pos]) begin
        r.writeback_valid = 1'b1;
        r.writeback_address = vb_addr[pos];
      end
    end
    vb_valid[pos] = 1'b0;
    for (int j = 0; j < nv; j++)
      if (vb_valid[j] && j != pos && vb_age[j] < NVICT-1) vb_age[j] = vb_age[j] + 3'd1;
    vb_addr[pos] = ev_a;
    vb_dirty[pos] = ev_d;
    vb_valid[pos] = 1'b1;
    vb_age[pos] = '0;
    place_line(base, lru, a, wr, n);
    r.fill_valid = 1'b1;
    r.fill_address = a;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  // one APB write: setup, then access
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      savc_pkg::REG_OFFSET_BITS: cfg_offset = val[3:0];
      savc_pkg::REG_INDEX_BITS:  cfg_index = val[3:0];
      savc_pkg::REG_WAYS:        cfg_ways = val[2:0];
      default:                   cfg_victims = val[3:0];
    endcase
  endtask

  // send one access beat; valid stays high afterwards
  task automatic send_access(bit op, logic [31:0] a);
    if (!calm && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    address <= a;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(predict_access(op, a));
  endtask

  // lower valid and wait until every result is back
  task automatic drain;
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_config(int ob, int ib, int w, int v);
    write_reg(savc_pkg::REG_OFFSET_BITS, ob);
    write_reg(savc_pkg::REG_INDEX_BITS, ib);
    write_reg(savc_pkg::REG_WAYS, w);
    write_reg(savc_pkg::REG_VICTIMS, v);
  endtask

  // addresses drawn from a few tags over a few sets, plus some noise
  function automatic logic [31:0] pick_address();
    int ob, ib;
    logic [31:0] a;
    if ($urandom_range(0, 99) < 10) return $urandom;
    ob = cfg_offset;
    ib = (cfg_index > IDX_MAX) ? IDX_MAX : cfg_index;
    a = tag_pool[$urandom_range(0, 15)] << (ob + ib);
    a |= ($urandom_range(0, set_span - 1) & ((32'd1 << ib) - 1)) << ob;
    a |= $urandom & ((32'd1 << ob) - 1);
    return a;
  endfunction

  task automatic run_random(int count);
    for (int k = 0; k < 16; k++) tag_pool[k] = $urandom;
    set_span = $urandom_range(1, 4);
    for (int k = 0; k < count; k++) send_access(1'($urandom_range(0, 1)), pick_address());
    drain();
  endtask

  // fill one set past the L1 and the victim buffer, then revisit
  task automatic test_directed;
    send_access(OP_READ, 32'h0000_0000);
    send_access(OP_WRITE, 32'hFFFF_FFFF);
    send_access(OP_WRITE, 32'h0000_0004);
    for (int t = 1; t <= 14; t++) send_access(t[0], t << 11);
    send_access(OP_READ, 32'd5 << 11);
    send_access(OP_READ, 32'd2 << 11);
    send_access(OP_WRITE, 32'd3 << 11);
    send_access(OP_READ, 32'd2 << 11);
    send_access(OP_READ, 32'd20 << 11);
    send_access(OP_WRITE, 32'd21 << 11);
    drain();
  endtask

  task automatic test_configs;
    set_config(2, 0, 1, 1);   run_random(250);
    set_config(8, 10, 4, 8);  run_random(250);
    set_config(15, 15, 7, 15); run_random(200);
    set_config(0, 3, 0, 0);   run_random(200);
    set_config(3, 2, 2, 3);   run_random(250);
    calm = 1'b1;
    set_config(4, 1, 3, 5);   run_random(300);
    calm = 1'b0;
    set_config(5, 6, 4, 8);   run_random(300);
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure;
    set_config(2, 1, 2, 2);
    hold_reqs++;
    run_random(250);
  endtask

  // output side: random stalls, plus long hold on request
  always @(posedge clk) begin : stall_gen
    int seen, left;
    if (rst) begin
      out_stall <= 1'b0;
      seen = 0;
      left = 0;
    end else begin
      if (seen != hold_reqs) begin
        seen = hold_reqs;
        left = HOLD_CYCLES;
      end
      if (left > 0) begin
        left--;
        out_stall <= 1'b1;
      end else out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 7);
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin : result_check
    access_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) report_mismatch("result beat with none expected");
      else begin
        exp_r = expected_results.pop_front();
        if (hit !== exp_r.hit)
          report_mismatch($sformatf("hit %b exp %b", hit, exp_r.hit));
        if (victim_hit !== exp_r.victim_hit)
          report_mismatch($sformatf("victim_hit %b exp %b", victim_hit, exp_r.victim_hit));
        if (fill_valid !== exp_r.fill_valid)
          report_mismatch($sformatf("fill_valid %b exp %b", fill_valid, exp_r.fill_valid));
        if (fill_address !== exp_r.fill_address)
          report_mismatch($sformatf("fill_address %h exp %h", fill_address,
                                    exp_r.fill_address));
        if (writeback_valid !== exp_r.writeback_valid)
          report_mismatch($sformatf("writeback_valid %b exp %b", writeback_valid,
                                    exp_r.writeback_valid));
        if (writeback_address !== exp_r.writeback_address)
          report_mismatch($sformatf("writeback_address %h exp %h", writeback_address,
                                    exp_r.writeback_address));
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("** set_assoc_cache_with_victim_buffer: FAILED **");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    operation = 1'b0;
    address = '0;
    errors = 0;
    calm = 1'b0;
    hold_reqs = 0;
    cfg_offset = savc_pkg::OFFSET_BITS_RST;
    cfg_index = savc_pkg::INDEX_BITS_RST;
    cfg_ways = savc_pkg::WAYS_RST;
    cfg_victims = savc_pkg::VICTIMS_RST;
    for (int k = 0; k < NSETS*NWAYS; k++) begin
      l1_valid[k] = 1'b0;
      l1_dirty[k] = 1'b0;
      l1_age[k] = '0;
      l1_addr[k] = '0;
    end
    for (int k = 0; k < NVICT; k++) begin
      vb_valid[k] = 1'b0;
      vb_dirty[k] = 1'b0;
      vb_age[k] = '0;
      vb_addr[k] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_configs();
    test_backpressure();
    repeat (10) @(posedge clk);
    if (errors == 0) $display("** set_assoc_cache_with_victim_buffer: PASSED **");
    else $display("** set_assoc_cache_with_victim_buffer: FAILED **");
    $finish;
  end

endmodule
